[rtl/core/nta_pkg.sv]
// Neighbor table package: sizes, status codes, controller/datapath command types.
// No dependencies; used by every other file of the block.
`default_nettype none

package nta_pkg;

   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

   localparam int ADDR_W     = 48;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 5;
   localparam int COUNT_W    = 6;
   localparam int LIMIT_W    = 3;

   localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = 3'd6;

   localparam logic [STATUS_W-1:0] ST_REFRESH = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_AGED    = 2'd3;

   localparam logic ACT_BEACON = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   typedef struct packed {
      logic             load;      // latch a new item, clear search results
      logic             tick_mode; // item is an aging tick
      logic             rd_en;     // scan: read entry idx
      logic             tick_upd;  // tick: age entry idx
      logic             commit;    // write back beacon result, load response
      logic [CNT_W-1:0] idx;
   } nta_cmd_type;

   typedef struct packed {
      logic rsp_busy;              // response register holds an untaken result
   } nta_sts_type;

endpackage

`default_nettype wire

[rtl/core/nta_req_if.sv]
// Request channel: valid/ready handshake with beacon or aging tick payload.
// Depends on nta_pkg.
`default_nettype none

interface nta_req_if;
   import nta_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] source_addr;

   modport source (output valid, action, source_addr, input ready);
   modport sink   (input valid, action, source_addr, output ready);

endinterface

`default_nettype wire

[rtl/core/nta_rsp_if.sv]
// Response channel: valid/ready handshake with one result per request.
// Depends on nta_pkg.
`default_nettype none

interface nta_rsp_if;
   import nta_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [COUNT_W-1:0]  removed_count;
   logic [COUNT_W-1:0]  valid_count;

   modport source (output valid, status, slot, removed_count, valid_count, input ready);
   modport sink   (input valid, status, slot, removed_count, valid_count, output ready);

endinterface

`default_nettype wire

[rtl/core/neighbor_table_with_aging.sv]
// Neighbor table with aging, top level: controller plus datapath.
// Depends on nta_pkg, nta_req_if, nta_rsp_if, nta_ctrl, nta_dpath.
//
//  channel  | direction | transfer / write          | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  req_ch   | in        | valid && ready            | action, source_addr
//  rsp_ch   | out       | valid && ready            | status, slot, removed_count, valid_count
//  csr      | in        | csr_wr_en                 | csr_wr_data = miss_limit
//
// Beacon: accept, a scan of every entry (registered memory read, then compare), then commit.
// Aging tick: accept, an aging pass over every entry, then commit.
// One item in flight; the entry walk over the address memory port sets the rate.
// Reset empties the table at once and loads miss_limit with 6.
// A result waiting on rsp_ch holds the commit cycle of the next item until it is taken.
`default_nettype none

module neighbor_table_with_aging (
   input  wire logic                        clock,
   input  wire logic                        reset,
   nta_req_if.sink                          req_ch,
   nta_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic [nta_pkg::LIMIT_W-1:0] csr_wr_data
);
   import nta_pkg::*;

   nta_cmd_type cmd;
   nta_sts_type sts;

   nta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   nta_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_addr    (req_ch.source_addr),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp_ch)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.rsp_busy)
      else $error("commit while response register occupied");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an item is in work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.valid_count <= COUNT_W'(TABLE_SIZE)))
      else $error("valid count above table size");

   a_tick_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_AGED) |-> (rsp_ch.slot == '0))
      else $error("aging result with nonzero slot");

   a_beacon_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_AGED) |-> (rsp_ch.removed_count == '0))
      else $error("beacon result with removed entries");

endmodule

`default_nettype wire

[rtl/core/nta_ctrl.sv]
// Neighbor table controller: one-hot FSM and entry index counter.
// Depends on nta_pkg; drives the datapath through nta_cmd_type.
`default_nettype none

module nta_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_ready,
   input  wire nta_pkg::nta_sts_type sts,
   output nta_pkg::nta_cmd_type      cmd
);
   import nta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_TICK = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] END_IDX  = CNT_W'(TABLE_SIZE);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             tick_ff, tick_in;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      tick_in  = tick_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               tick_in  = (req_action == ACT_TICK);
               state_in = (req_action == ACT_TICK) ? S_TICK : S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == END_IDX) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_TICK: begin
            if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         tick_ff  <= tick_in;
      end
   end

   always_comb begin
      cmd.load      = accept;
      cmd.tick_mode = tick_ff;
      cmd.rd_en     = (state_ff == S_SCAN) && (idx_ff != END_IDX);
      cmd.tick_upd  = (state_ff == S_TICK);
      cmd.commit    = (state_ff == S_DONE) && !sts.rsp_busy;
      cmd.idx       = idx_ff;
   end

endmodule

`default_nettype wire

[rtl/core/nta_dpath.sv]
// Neighbor table datapath: address memory, entry flags, search and aging logic,
// miss limit register and response register. Depends on nta_pkg and nta_rsp_if.
`default_nettype none

module nta_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire nta_pkg::nta_cmd_type        cmd,
   output nta_pkg::nta_sts_type             sts,
   input  wire logic [nta_pkg::ADDR_W-1:0]  req_addr,
   input  wire logic                        csr_wr_en,
   input  wire logic [nta_pkg::LIMIT_W-1:0] csr_wr_data,
   nta_rsp_if.source                        rsp
);
   import nta_pkg::*;

   logic [ADDR_W-1:0]  addr_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [TABLE_SIZE-1:0] heard_ff;
   logic [LIMIT_W-1:0] misses_ff [TABLE_SIZE];

   logic [LIMIT_W-1:0] limit_ff;
   logic [ADDR_W-1:0]  key_ff;

   // scan compare stage
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic               rd_valid_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;

   logic               hit_ff, free_ff;
   logic [IDX_W-1:0]   hit_slot_ff, free_slot_ff;
   logic [COUNT_W-1:0] vcount_ff, removed_ff;

   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [COUNT_W-1:0] rsp_removed_ff, rsp_vcount_ff;

   logic [IDX_W-1:0]   e;
   logic [LIMIT_W:0]   miss_next;
   logic               age_clear, age_remove, age_bump;
   logic               cmp_hit, do_fill;

   assign e          = cmd.idx[IDX_W-1:0];
   assign miss_next  = {1'b0, misses_ff[e]} + (LIMIT_W+1)'(1);
   assign age_clear  = cmd.tick_upd && valid_ff[e] && heard_ff[e];
   assign age_remove = cmd.tick_upd && valid_ff[e] && !heard_ff[e]
                       && (miss_next >= {1'b0, limit_ff});
   assign age_bump   = cmd.tick_upd && valid_ff[e] && !heard_ff[e] && !age_remove;

   assign cmp_hit    = cmp_vld_ff && rd_valid_ff && (rd_addr_ff == key_ff) && !hit_ff;
   assign do_fill    = cmd.commit && !cmd.tick_mode && !hit_ff && free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MISS_LIMIT_RST;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // address memory: one read and one write port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_addr_ff <= addr_mem[e];
      end
      if (do_fill) begin
         addr_mem[free_slot_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_addr;
      end
      rd_valid_ff <= valid_ff[e];
      cmp_idx_ff  <= e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         hit_slot_ff  <= '0;
         free_slot_ff <= '0;
      end else begin
         cmp_vld_ff <= cmd.rd_en;
         if (cmd.load) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (cmp_vld_ff) begin
            if (!rd_valid_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= cmp_idx_ff;
            end
            if (cmp_hit) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= cmp_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (age_remove) begin
            valid_ff[e] <= 1'b0;
         end
         if (do_fill) begin
            valid_ff[free_slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (age_clear) begin
         heard_ff[e]  <= 1'b0;
         misses_ff[e] <= '0;
      end
      if (age_remove) begin
         misses_ff[e] <= '0;
      end
      if (age_bump) begin
         misses_ff[e] <= miss_next[LIMIT_W-1:0];
      end
      if (cmd.commit && !cmd.tick_mode && hit_ff) begin
         heard_ff[hit_slot_ff] <= 1'b1;
      end
      if (do_fill) begin
         heard_ff[free_slot_ff]  <= 1'b1;
         misses_ff[free_slot_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff  <= '0;
         removed_ff <= '0;
      end else begin
         if (cmd.load) begin
            removed_ff <= '0;
         end else if (age_remove) begin
            removed_ff <= removed_ff + COUNT_W'(1);
         end
         if (age_remove) begin
            vcount_ff <= vcount_ff - COUNT_W'(1);
         end else if (do_fill) begin
            vcount_ff <= vcount_ff + COUNT_W'(1);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_removed_ff <= cmd.tick_mode ? removed_ff : '0;
         rsp_vcount_ff  <= do_fill ? (vcount_ff + COUNT_W'(1)) : vcount_ff;
         if (cmd.tick_mode) begin
            status_ff <= ST_AGED;
            slot_ff   <= '0;
         end else if (hit_ff) begin
            status_ff <= ST_REFRESH;
            slot_ff   <= SLOT_W'(hit_slot_ff);
         end else if (free_ff) begin
            status_ff <= ST_ADDED;
            slot_ff   <= SLOT_W'(free_slot_ff);
         end else begin
            status_ff <= ST_DROPPED;
            slot_ff   <= '0;
         end
      end
   end

   assign sts.rsp_busy      = rsp_valid_ff && !rsp.ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.slot          = slot_ff;
   assign rsp.removed_count = rsp_removed_ff;
   assign rsp.valid_count   = rsp_vcount_ff;

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for neighbor_table_with_aging: beacons and aging ticks in, one result each.
// Depends on nta_pkg, nta_req_if, nta_rsp_if and the RTL of the block.

module tb;
   import nta_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [COUNT_W-1:0]  removed;
      logic [COUNT_W-1:0]  vcount;
   } nbr_rsp_type;

   typedef struct packed {
      logic              act;
      logic [ADDR_W-1:0] addr;
      logic              typed;
      nbr_rsp_type       exp;
   } stim_row_type;

   localparam int NUM_PHASES     = 10;
   localparam int PHASE_ITEMS    = 193;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 300;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   nta_req_if req_if ();
   nta_rsp_if rsp_if ();

   neighbor_table_with_aging u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow table
   logic               nbr_valid  [TABLE_SIZE];
   logic [ADDR_W-1:0]  nbr_addr   [TABLE_SIZE];
   logic               nbr_heard  [TABLE_SIZE];
   logic [LIMIT_W-1:0] nbr_misses [TABLE_SIZE];
   logic [LIMIT_W-1:0] cur_limit;

   nbr_rsp_type pending_rsp[$];
   int          fail_count = 0;

   logic        row_typed;
   nbr_rsp_type row_exp;

   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   bit hold_long    = 1'b0;

   stim_row_type directed_rows [21] = '{
      '{ACT_BEACON, 48'h0000_0000_0000, 1'b1, '{ST_ADDED,   5'd31, 6'd0, 6'd1}},
      '{ACT_BEACON, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_ADDED,   5'd30, 6'd0, 6'd2}},
      '{ACT_BEACON, 48'h0000_0000_0000, 1'b1, '{ST_REFRESH, 5'd31, 6'd0, 6'd2}},
      '{ACT_BEACON, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_REFRESH, 5'd30, 6'd0, 6'd2}},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b1, '{ST_AGED,    5'd0,  6'd0, 6'd2}},
      '{ACT_BEACON, 48'h5555_5555_5555, 1'b1, '{ST_ADDED,   5'd29, 6'd0, 6'd3}},
      '{ACT_BEACON, 48'hAAAA_AAAA_AAAA, 1'b1, '{ST_ADDED,   5'd28, 6'd0, 6'd4}},
      '{ACT_TICK,   48'hFFFF_FFFF_FFFF, 1'b0, '0},
      '{ACT_BEACON, 48'h0000_0000_0000, 1'b1, '{ST_REFRESH, 5'd31, 6'd0, 6'd4}},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b0, '0},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b0, '0},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b0, '0},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b0, '0},
      '{ACT_TICK,   48'h5555_5555_5555, 1'b0, '0},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b0, '0},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b0, '0},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b1, '{ST_AGED,    5'd0,  6'd0, 6'd0}},
      '{ACT_BEACON, 48'h8000_0000_0001, 1'b1, '{ST_ADDED,   5'd31, 6'd0, 6'd1}},
      '{ACT_BEACON, 48'h0000_0000_0001, 1'b1, '{ST_ADDED,   5'd30, 6'd0, 6'd2}},
      '{ACT_BEACON, 48'h8000_0000_0001, 1'b1, '{ST_REFRESH, 5'd31, 6'd0, 6'd2}},
      '{ACT_TICK,   48'h0000_0000_0000, 1'b1, '{ST_AGED,    5'd0,  6'd0, 6'd2}}
   };

   logic [LIMIT_W-1:0] limit_plan [NUM_PHASES] = '{
      3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7, 3'd0, 3'd4, 3'd5, 3'd3
   };

   function automatic nbr_rsp_type learn_or_age(input logic act,
                                                input logic [ADDR_W-1:0] addr);
      nbr_rsp_type r;
      bit          hit;
      bit          have_free;
      int          free_idx;
      int          removed;
      int          live;
      int          nxt;
      r         = '0;
      hit       = 1'b0;
      have_free = 1'b0;
      free_idx  = 0;
      removed   = 0;
      live      = 0;
      if (act == ACT_BEACON) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!nbr_valid[i]) begin
               have_free = 1'b1;
               free_idx  = i;
            end else if (nbr_addr[i] == addr) begin
               nbr_heard[i] = 1'b1;
               r.slot       = SLOT_W'(i);
               hit          = 1'b1;
               break;
            end
         end
         if (hit) begin
            r.status = ST_REFRESH;
         end else if (have_free) begin
            nbr_valid[free_idx]  = 1'b1;
            nbr_addr[free_idx]   = addr;
            nbr_heard[free_idx]  = 1'b1;
            nbr_misses[free_idx] = '0;
            r.slot               = SLOT_W'(free_idx);
            r.status             = ST_ADDED;
         end else begin
            r.status = ST_DROPPED;
         end
      end else begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (nbr_valid[i]) begin
               if (nbr_heard[i]) begin
                  nbr_heard[i]  = 1'b0;
                  nbr_misses[i] = '0;
               end else begin
                  nxt = int'(nbr_misses[i]) + 1;
                  if (nxt >= int'(cur_limit)) begin
                     nbr_valid[i]  = 1'b0;
                     nbr_misses[i] = '0;
                     removed++;
                  end else begin
                     nbr_misses[i] = LIMIT_W'(nxt);
                  end
               end
            end
         end
         r.status  = ST_AGED;
         r.removed = COUNT_W'(removed);
      end
      for (int i = 0; i < TABLE_SIZE; i++)
         if (nbr_valid[i])
            live++;
      r.vcount = COUNT_W'(live);
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : track_table
      nbr_rsp_type got;
      nbr_rsp_type want;
      nbr_rsp_type calc;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            nbr_valid[i]  = 1'b0;
            nbr_addr[i]   = '0;
            nbr_heard[i]  = 1'b0;
            nbr_misses[i] = '0;
         end
         cur_limit = MISS_LIMIT_RST;
         pending_rsp.delete();
      end else begin
         if (csr_wr_en)
            cur_limit = csr_wr_data;
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.status, rsp_if.slot, rsp_if.removed_count, rsp_if.valid_count};
            if (pending_rsp.size() == 0) begin
               $error("result transfer with nothing expected: status %0d slot %0d",
                      got.status, got.slot);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("status",        want.status,  got.status);
               check_field("slot",          want.slot,    got.slot);
               check_field("removed_count", want.removed, got.removed);
               check_field("valid_count",   want.vcount,  got.vcount);
            end
         end
         if (req_if.valid && req_if.ready) begin
            calc = learn_or_age(req_if.action, req_if.source_addr);
            pending_rsp.push_back(row_typed ? row_exp : calc);
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                            input logic typed, input nbr_rsp_type exp);
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.source_addr <= addr;
      row_typed          <= typed;
      row_exp            <= exp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [ADDR_W-1:0] addr_pool [48];
      int                pool_n;
      int                tick_pct;
      logic              act;
      logic [ADDR_W-1:0] addr;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_BEACON;
      req_if.source_addr <= '0;
      row_typed          <= 1'b0;
      row_exp            <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].act, directed_rows[i].addr,
                   directed_rows[i].typed, directed_rows[i].exp);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_limit(limit_plan[ph]);
         send_idle_on = (ph != 4) && (ph != NUM_PHASES - 1);
         recv_idle_on = send_idle_on;
         if (ph == 2)
            hold_long = 1'b1;
         pool_n   = $urandom_range(8, 48);
         tick_pct = $urandom_range(3, 45);
         if (ph == 1) begin
            pool_n   = 48;
            tick_pct = 2;
         end
         foreach (addr_pool[k])
            addr_pool[k] = {16'($urandom), 32'($urandom)};
         addr_pool[0] = '0;
         addr_pool[1] = '1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            act  = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_BEACON;
            addr = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                               : addr_pool[$urandom_range(0, pool_n - 1)];
            send_item(act, addr, 1'b0, '0);
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb failed");
      $finish;
   end

endmodule
